/* hdl/ud_pkg.sv */
// ud_pkg: shared types, constants and lead byte decode for the utf8 decoder
// no dependencies; imported by ud_decode, ud_fifo and utf8_decoder
`default_nettype none

package ud_pkg;

  // field widths
  localparam int unsigned CP_W    = 31;
  localparam int unsigned PEND_W  = 3;
  localparam int unsigned BYTE_W  = 8;

  // result queue depth and pointer width
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CONT = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_BAD_LEAD = 2'd3
  } ud_status_t;

  // one result word
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    ud_status_t      status;
    logic            last;
  } ud_result_t;

  // up to two results pushed into the queue for one input byte
  typedef struct packed {
    logic [1:0] n;
    ud_result_t res0;
    ud_result_t res1;
  } ud_push_t;

  // full outcome of one decode step
  typedef struct packed {
    ud_push_t          push;
    logic [CP_W-1:0]   acc_next;
    logic [PEND_W-1:0] pend_next;
  } ud_step_t;

  // what a byte does when taken as a lead byte
  typedef struct packed {
    logic              emit;
    logic [CP_W-1:0]   code_point;
    ud_status_t        status;
    logic              load;
    logic [CP_W-1:0]   acc;
    logic [PEND_W-1:0] pend;
  } ud_lead_t;

  function automatic ud_lead_t ud_lead(input logic [BYTE_W-1:0] b);
    ud_lead_t r;
    r = '0;
    r.status = ST_OK;
    // ascii passes through, leads load payload and count, rest is invalid
    priority if (b[7] == 1'b0) begin
      r.emit       = 1'b1;
      r.code_point = CP_W'(b);
    end else if (b[7:5] == 3'b110) begin
      r.load = 1'b1;
      r.acc  = CP_W'(b[4:0]);
      r.pend = PEND_W'(1);
    end else if (b[7:4] == 4'b1110) begin
      r.load = 1'b1;
      r.acc  = CP_W'(b[3:0]);
      r.pend = PEND_W'(2);
    end else if (b[7:3] == 5'b11110) begin
      r.load = 1'b1;
      r.acc  = CP_W'(b[2:0]);
      r.pend = PEND_W'(3);
    end else if (b[7:2] == 6'b111110) begin
      r.load = 1'b1;
      r.acc  = CP_W'(b[1:0]);
      r.pend = PEND_W'(4);
    end else if (b[7:1] == 7'b1111110) begin
      r.load = 1'b1;
      r.acc  = CP_W'(b[0]);
      r.pend = PEND_W'(5);
    end else begin
      r.emit   = 1'b1;
      r.status = ST_BAD_LEAD;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/ud_decode.sv */
// ud_decode: combinational decode of one byte against the sequence state
// depends on ud_pkg
`default_nettype none

module ud_decode (
  input  wire logic [ud_pkg::CP_W-1:0]   acc,
  input  wire logic [ud_pkg::PEND_W-1:0] pending,
  input  wire logic [ud_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                      end_of_buffer,
  output ud_pkg::ud_step_t               step
);
  import ud_pkg::*;

  logic              cont;
  logic [CP_W-1:0]   acc_shift;
  logic [PEND_W-1:0] pend_dec;
  ud_lead_t          lead;
  logic              run_lead;
  logic              va, vb, vc;
  ud_result_t        ra, rb, rc;
  logic [CP_W-1:0]   acc_n;
  logic [PEND_W-1:0] pend_n;
  logic [1:0]        cnt;

  always_comb begin
    cont      = (data_byte[7:6] == 2'b10);
    acc_shift = {acc[CP_W-7:0], data_byte[5:0]};
    pend_dec  = pending - PEND_W'(1);
    lead      = ud_lead(data_byte);
    run_lead  = 1'b0;
    va = 1'b0;
    vb = 1'b0;
    ra = '0;
    rb = '0;
    rc = '0;
    acc_n  = acc;
    pend_n = pending;

    // continuation or bad continuation of an open sequence
    if (pending != '0) begin
      if (cont) begin
        pend_n = pend_dec;
        if (pend_dec == '0) begin
          va            = 1'b1;
          ra.code_point = acc_shift;
          ra.status     = ST_OK;
          acc_n         = '0;
        end else begin
          acc_n = acc_shift;
        end
      end else begin
        va        = 1'b1;
        ra.status = ST_BAD_CONT;
        run_lead  = 1'b1;
      end
    end else begin
      run_lead = 1'b1;
    end

    // byte taken as a lead
    if (run_lead) begin
      vb            = lead.emit;
      rb.code_point = lead.code_point;
      rb.status     = lead.status;
      if (lead.load) begin
        acc_n  = lead.acc;
        pend_n = lead.pend;
      end else begin
        acc_n  = '0;
        pend_n = '0;
      end
    end

    // sequence still open at end of buffer
    vc        = end_of_buffer && (pend_n != '0);
    rc.status = ST_TRUNC;
    if (vc) begin
      acc_n  = '0;
      pend_n = '0;
    end

    // pack results in order, mark the final one
    cnt = 2'(va) + 2'(vb) + 2'(vc);
    step           = '0;
    step.acc_next  = acc_n;
    step.pend_next = pend_n;
    step.push.n    = cnt;
    if (va) begin
      step.push.res0 = ra;
      step.push.res1 = vb ? rb : rc;
    end else if (vb) begin
      step.push.res0 = rb;
      step.push.res1 = rc;
    end else begin
      step.push.res0 = rc;
      step.push.res1 = rc;
    end
    step.push.res0.last = (cnt == 2'd1);
    step.push.res1.last = (cnt == 2'd2);
  end

endmodule

`default_nettype wire

/* hdl/ud_fifo.sv */
// ud_fifo: small result queue, takes up to two words per cycle, gives one
// depends on ud_pkg
`default_nettype none

module ud_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_en,
  input  wire ud_pkg::ud_push_t push,
  output logic              space_ok,
  output logic              head_valid,
  output ud_pkg::ud_result_t head,
  input  wire logic         pop
);
  import ud_pkg::*;

  ud_result_t         mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic [FIFO_AW:0]   count_next;
  logic [1:0]         push_n;
  logic               do_pop;

  assign push_n     = push_en ? push.n : 2'd0;
  assign do_pop     = pop && head_valid;
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign space_ok   = (count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign count_next = count + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(do_pop);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_n);
      rd_ptr <= rd_ptr + FIFO_AW'(do_pop);
      count  <= count_next;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push.res1;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overfilled");
  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    push_en |-> space_ok)
    else $error("push without room for two words");
`endif

endmodule

`default_nettype wire

/* hdl/utf8_decoder.sv */
// utf8_decoder: byte stream in, code point words out
// input register, then result queue; the queue head drives the output
// throughput: one byte per cycle while the queue has room for two words;
//   the output drains one word per cycle while m_axis_tready is high
// rst (synchronous, active high) clears the open sequence and empties the queue
`default_nettype none

module utf8_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_buffer
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [30:0] code_point, [31] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  output logic             m_axis_tlast    // last_of_run
);
  import ud_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_eob;
  logic [CP_W-1:0]   acc;
  logic [PEND_W-1:0] pending;
  logic              fire;
  logic              space_ok;
  ud_step_t          step;
  ud_result_t        head;

  assign fire          = in_valid && space_ok;
  assign s_axis_tready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eob  <= s_axis_tlast;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      pending <= '0;
    end else if (fire) begin
      acc     <= step.acc_next;
      pending <= step.pend_next;
    end
  end

  ud_decode u_decode (
    .acc           (acc),
    .pending       (pending),
    .data_byte     (in_byte),
    .end_of_buffer (in_eob),
    .step          (step)
  );

  ud_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_en    (fire),
    .push       (step.push),
    .space_ok   (space_ok),
    .head_valid (m_axis_tvalid),
    .head       (head),
    .pop        (m_axis_tready)
  );

  // output word
  assign m_axis_tdata = {1'b0, head.code_point};
  assign m_axis_tuser = head.status;
  assign m_axis_tlast = head.last;

`ifndef SYNTH
  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(5))
    else $error("pending count out of range");
  a_eob_closes: assert property (@(posedge clk) disable iff (rst)
    (fire && in_eob) |=> (pending == '0))
    else $error("sequence left open after end of buffer");
`endif

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// testbench for utf8_decoder: directed byte table, then random utf-8 sequences with noise
// depends on ud_pkg (status codes, result word type) and the utf8_decoder rtl
`timescale 1ns / 100ps

module testbench;
  import ud_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BYTES = 1800;
  localparam int unsigned DRAIN_CYCLES = 12;

  // one row of the directed table; n < 0 means the predictor supplies the words
  typedef struct {
    logic [7:0]      data;
    logic            eob;
    int              n;
    logic [CP_W-1:0] cp0;
    ud_status_t      st0;
    logic [CP_W-1:0] cp1;
    ud_status_t      st1;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  utf8_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  // decoder model state and word stores
  logic [CP_W-1:0]   acc_model  = '0;
  logic [PEND_W-1:0] pend_model = '0;
  ud_result_t        step_words[$];
  ud_result_t        words_due[$];
  stim_row_t         stim_rows[$];
  int unsigned       errors = 0;
  int unsigned       cycles = 0;
  bit                no_gaps = 1'b0;

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void put_word(input logic [CP_W-1:0] cp, input ud_status_t st);
    ud_result_t w;
    w.code_point = cp;
    w.status     = st;
    w.last       = 1'b0;
    step_words.push_back(w);
  endfunction

  // byte taken as the start of a new sequence
  function automatic void take_lead(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      put_word(CP_W'(b), ST_OK);
    end else if (b[7:5] == 3'b110) begin
      acc_model  = CP_W'(b[4:0]);
      pend_model = 3'd1;
    end else if (b[7:4] == 4'b1110) begin
      acc_model  = CP_W'(b[3:0]);
      pend_model = 3'd2;
    end else if (b[7:3] == 5'b11110) begin
      acc_model  = CP_W'(b[2:0]);
      pend_model = 3'd3;
    end else if (b[7:2] == 6'b111110) begin
      acc_model  = CP_W'(b[1:0]);
      pend_model = 3'd4;
    end else if (b[7:1] == 7'b1111110) begin
      acc_model  = CP_W'(b[0]);
      pend_model = 3'd5;
    end else begin
      put_word('0, ST_BAD_LEAD);
    end
  endfunction

  // words caused by one accepted byte, left in step_words
  function automatic void decode_byte(input logic [7:0] b, input logic eob);
    step_words.delete();
    if (pend_model != 0) begin
      if (b[7:6] == 2'b10) begin
        acc_model  = {acc_model[CP_W-7:0], b[5:0]};
        pend_model = pend_model - 3'd1;
        if (pend_model == 0) begin
          put_word(acc_model, ST_OK);
          acc_model = '0;
        end
      end else begin
        // sequence broken: flag it, then treat the byte as a fresh lead
        put_word('0, ST_BAD_CONT);
        acc_model  = '0;
        pend_model = '0;
        take_lead(b);
      end
    end else begin
      take_lead(b);
    end
    // buffer ends with a sequence still open
    if (eob && pend_model != 0) begin
      put_word('0, ST_TRUNC);
      acc_model  = '0;
      pend_model = '0;
    end
    if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
  endfunction

  function automatic void row(input logic [7:0] d, input logic e = 1'b0, input int n = -1,
                              input logic [CP_W-1:0] cp0 = '0, input ud_status_t st0 = ST_OK,
                              input logic [CP_W-1:0] cp1 = '0, input ud_status_t st1 = ST_OK);
    stim_row_t r;
    r.data = d;
    r.eob  = e;
    r.n    = n;
    r.cp0  = cp0;
    r.st0  = st0;
    r.cp1  = cp1;
    r.st1  = st1;
    stim_rows.push_back(r);
  endfunction

  function automatic logic [7:0] lead_byte(input int len, input logic [7:0] r);
    case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      4:       return {5'b11110, r[2:0]};
      5:       return {6'b111110, r[1:0]};
      default: return {7'b1111110, r[0]};
    endcase
  endfunction

  // offer one byte and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic eob);
    while (!no_gaps && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eob;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // send a random byte and queue what the model says it yields
  task automatic send_random(input logic [7:0] b);
    logic eob;
    eob = ($urandom_range(0, 99) < 4);
    send_byte(b, eob);
    decode_byte(b, eob);
    foreach (step_words[i]) words_due.push_back(step_words[i]);
  endtask

  // output side: random stalls, result checks, timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("utf8_decoder regression: fail");
      $finish;
    end else begin
      m_tready <= !rst && (no_gaps || $urandom_range(0, 99) >= 15);
      if (!rst && m_tvalid && m_tready) begin
        if (words_due.size() == 0) begin
          $error("unexpected word: code_point %h status %0d last %b",
                 m_tdata[CP_W-1:0], m_tuser, m_tlast);
          errors = errors + 1;
        end else begin
          if (m_tdata[CP_W-1:0] !== words_due[0].code_point) begin
            $error("code_point: expected %h, got %h", words_due[0].code_point,
                   m_tdata[CP_W-1:0]);
            errors = errors + 1;
          end
          if (m_tuser !== words_due[0].status) begin
            $error("status: expected %0d, got %0d", words_due[0].status, m_tuser);
            errors = errors + 1;
          end
          if (m_tlast !== words_due[0].last) begin
            $error("last_of_run: expected %b, got %b", words_due[0].last, m_tlast);
            errors = errors + 1;
          end
          void'(words_due.pop_front());
        end
      end
    end
  end

  // stimulus
  initial begin
    ud_result_t w;
    logic [7:0] b;
    int len;
    int kind;
    int conts;
    int unsigned sent;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: extremes, lead lengths 1, 2, 3 and 6, every error path
    row(8'h00, 1'b0, 1, 31'h00, ST_OK);
    row(8'h7F, 1'b0, 1, 31'h7F, ST_OK);
    row(8'h80, 1'b0, 1, '0, ST_BAD_LEAD);
    row(8'hFE, 1'b0, 1, '0, ST_BAD_LEAD);
    row(8'hFF, 1'b0, 1, '0, ST_BAD_LEAD);
    row(8'hC3);
    row(8'hA9);
    row(8'hE2);
    row(8'h82);
    row(8'hAC);
    // six byte form filling all 31 bits
    row(8'hFD);
    repeat (5) row(8'hBF);
    // ascii in place of a continuation: error, then the ascii itself
    row(8'hC3);
    row(8'h41, 1'b0, 2, '0, ST_BAD_CONT, 31'h41, ST_OK);
    // lead in place of a continuation, then invalid lead in place of one
    row(8'hE2);
    row(8'hC3, 1'b0, 1, '0, ST_BAD_CONT);
    row(8'hFF, 1'b0, 2, '0, ST_BAD_CONT, '0, ST_BAD_LEAD);
    // buffer end with a sequence open
    row(8'hE2, 1'b1, 1, '0, ST_TRUNC);
    row(8'hC3);
    row(8'hE2, 1'b1, 2, '0, ST_BAD_CONT, '0, ST_TRUNC);
    row(8'h7F, 1'b1, 1, 31'h7F, ST_OK);

    foreach (stim_rows[i]) begin
      send_byte(stim_rows[i].data, stim_rows[i].eob);
      decode_byte(stim_rows[i].data, stim_rows[i].eob);
      if (stim_rows[i].n < 0) begin
        foreach (step_words[k]) words_due.push_back(step_words[k]);
      end else begin
        for (int k = 0; k < stim_rows[i].n; k++) begin
          w.code_point = (k == 0) ? stim_rows[i].cp0 : stim_rows[i].cp1;
          w.status     = (k == 0) ? stim_rows[i].st0 : stim_rows[i].st1;
          w.last       = (k == stim_rows[i].n - 1);
          words_due.push_back(w);
        end
      end
    end

    // random part: mostly well-formed sequences, some noise and cut-off sequences
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      no_gaps = (sent >= 700 && sent < 1000);
      kind = $urandom_range(0, 99);
      len  = $urandom_range(0, 99);
      len  = (len < 30) ? 1 : (len < 50) ? 2 : (len < 65) ? 3 :
             (len < 80) ? 4 : (len < 90) ? 5 : 6;
      if (kind >= 80 && kind < 90) begin
        b = 8'($urandom);
        send_random(b);
        sent++;
      end else begin
        conts = (kind < 80 || len == 1) ? len - 1 : $urandom_range(0, len - 2);
        b = lead_byte(len, 8'($urandom));
        send_random(b);
        sent++;
        for (int k = 0; k < conts; k++) begin
          b = {2'b10, 6'($urandom)};
          send_random(b);
          sent++;
        end
      end
    end
    no_gaps = 1'b0;

    s_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("utf8_decoder regression: pass");
    end else begin
      $display("utf8_decoder regression: fail");
    end
    $finish;
  end

endmodule
